@@ rtl/assert_macros.svh @@
// -----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; they compile away for synthesis.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

@@ rtl/bpft_pkg.sv @@
// -----------------------------------------------------------------------------
// Packet field tokenizer package
// Shared sizes, parse phases, field codes and the per-packet result bundle.
// -----------------------------------------------------------------------------
package bpft_pkg;

  localparam int unsigned MAX_PACKET_BYTES = 2048;
  localparam int unsigned OFF_W            = $clog2(MAX_PACKET_BYTES);
  localparam int unsigned CNT_W            = $clog2(MAX_PACKET_BYTES + 1);
  localparam int unsigned NUM_W            = 32;
  localparam int unsigned FIELD_W          = 11;
  localparam int unsigned NUM_NUMBERS      = 2;
  localparam int unsigned NUM_STRINGS      = 4;

  localparam logic [FIELD_W-1:0] FIELD_MAX = 11'd2047;

  typedef enum logic [2:0] {
    PH_NUM0_WS,
    PH_NUM0_DIG,
    PH_NUM1_WS,
    PH_NUM1_DIG,
    PH_PRE_WS,
    PH_STR_BODY,
    PH_STR_TAIL,
    PH_DONE
  } phase_e;

  typedef enum logic [2:0] {
    FID_TYPE,
    FID_STATE,
    FID_URI,
    FID_LOCATION,
    FID_INFO,
    FID_MODEL
  } field_id_e;

  typedef struct packed {
    logic [NUM_NUMBERS-1:0][NUM_W-1:0] numbers;
    logic [NUM_STRINGS-1:0][CNT_W-1:0] starts;
    logic [NUM_STRINGS-1:0][CNT_W-1:0] lengths;
    logic                              truncated;
  } packet_t;

endpackage

@@ rtl/bpft_parser.sv @@
// -----------------------------------------------------------------------------
// Packet field parser
// Consumes one byte per beat and keeps the number and string bookkeeping.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module bpft_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             beat_i,
  input  logic [7:0]       byte_i,
  input  logic             last_i,
  output bpft_pkg::packet_t snap_o
);
  import bpft_pkg::*;

  localparam logic [7:0] CHAR_QUOTE = 8'h22;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [1:0] LAST_STR   = 2'(NUM_STRINGS - 1);
  localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(MAX_PACKET_BYTES - 1);

  phase_e                            phase_q, phase_d;
  logic [1:0]                        str_q, str_d;
  logic [OFF_W-1:0]                  off_q, off_d;
  logic                              quoted_q, quoted_d;
  logic                              ovf_q, ovf_d;
  logic [NUM_NUMBERS-1:0][NUM_W-1:0] num_q, num_d;
  logic [NUM_STRINGS-1:0][CNT_W-1:0] start_q, start_d;
  logic [NUM_STRINGS-1:0][CNT_W-1:0] len_q, len_d;

  logic       is_ws, is_dig, is_quote;
  logic       enter;
  logic [1:0] enter_idx;
  logic       grow;
  logic [3:0] digit;

  function automatic logic [NUM_W-1:0] mac10(input logic [NUM_W-1:0] n,
                                             input logic [3:0] d);
    return {n[NUM_W-4:0], 3'b000} + {n[NUM_W-2:0], 1'b0} + NUM_W'(d);
  endfunction

  assign is_ws    = (byte_i == CHAR_SPACE) || (byte_i inside {[8'h09:8'h0D]});
  assign is_dig   = byte_i inside {[8'h30:8'h39]};
  assign is_quote = (byte_i == CHAR_QUOTE);
  assign digit    = 4'(byte_i - CHAR_ZERO);

  always_comb begin
    phase_d   = phase_q;
    str_d     = str_q;
    off_d     = off_q;
    quoted_d  = quoted_q;
    ovf_d     = ovf_q;
    num_d     = num_q;
    start_d   = start_q;
    len_d     = len_q;
    enter     = 1'b0;
    enter_idx = '0;
    grow      = 1'b0;

    if (!ovf_q) begin
      case (phase_q)
        PH_NUM0_WS: begin
          if (is_dig) begin
            phase_d  = PH_NUM0_DIG;
            num_d[0] = mac10(num_q[0], digit);
          end else if (!is_ws) begin
            enter = 1'b1;
          end
        end
        PH_NUM0_DIG: begin
          if (is_dig) begin
            num_d[0] = mac10(num_q[0], digit);
          end else if (is_ws) begin
            phase_d = PH_NUM1_WS;
          end else begin
            enter = 1'b1;
          end
        end
        PH_NUM1_WS: begin
          if (is_dig) begin
            phase_d  = PH_NUM1_DIG;
            num_d[1] = mac10(num_q[1], digit);
          end else if (!is_ws) begin
            enter = 1'b1;
          end
        end
        PH_NUM1_DIG: begin
          if (is_dig) begin
            num_d[1] = mac10(num_q[1], digit);
          end else if (is_ws) begin
            phase_d = PH_PRE_WS;
          end else begin
            enter = 1'b1;
          end
        end
        PH_PRE_WS: begin
          if (!is_ws) begin
            enter = 1'b1;
          end
        end
        PH_STR_BODY: begin
          if (quoted_q ? is_quote : is_ws) begin
            phase_d = PH_STR_TAIL;
          end else begin
            grow = 1'b1;
          end
        end
        PH_STR_TAIL: begin
          if (!is_ws) begin
            if (str_q != LAST_STR) begin
              enter     = 1'b1;
              enter_idx = str_q + 2'd1;
            end else begin
              phase_d = PH_DONE;
            end
          end
        end
        default: begin
          phase_d = PH_DONE;
        end
      endcase

      if (enter) begin
        str_d    = enter_idx;
        quoted_d = is_quote;
        if (is_quote) begin
          phase_d = PH_STR_BODY;
        end else if (is_ws) begin
          phase_d = PH_STR_TAIL;
        end else begin
          phase_d = PH_STR_BODY;
        end
      end

      for (int i = 0; i < NUM_STRINGS; i++) begin
        if (enter && (enter_idx == 2'(i))) begin
          start_d[i] = is_quote ? CNT_W'(off_q) + CNT_W'(1) : CNT_W'(off_q);
          len_d[i]   = (is_quote || is_ws) ? '0 : CNT_W'(1);
        end else if (grow && (str_q == 2'(i))) begin
          len_d[i] = len_q[i] + CNT_W'(1);
        end
      end

      if (off_q == OFF_LAST) begin
        if (!last_i) begin
          ovf_d = 1'b1;
        end
      end else begin
        off_d = off_q + OFF_W'(1);
      end
    end
  end

  always_comb begin
    snap_o.numbers   = num_d;
    snap_o.starts    = start_d;
    snap_o.lengths   = len_d;
    snap_o.truncated = ovf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_NUM0_WS;
      str_q    <= '0;
      off_q    <= '0;
      quoted_q <= 1'b0;
      ovf_q    <= 1'b0;
      num_q    <= '0;
      start_q  <= '0;
      len_q    <= '0;
    end else if (beat_i) begin
      if (last_i) begin
        phase_q  <= PH_NUM0_WS;
        str_q    <= '0;
        off_q    <= '0;
        quoted_q <= 1'b0;
        ovf_q    <= 1'b0;
        num_q    <= '0;
        start_q  <= '0;
        len_q    <= '0;
      end else begin
        phase_q  <= phase_d;
        str_q    <= str_d;
        off_q    <= off_d;
        quoted_q <= quoted_d;
        ovf_q    <= ovf_d;
        num_q    <= num_d;
        start_q  <= start_d;
        len_q    <= len_d;
      end
    end
  end

  `ASSERT_PROP(a_ovf_at_end, clk_i, rst_ni, ovf_q |-> (off_q == OFF_LAST), "overflow away from last offset")
  `ASSERT_PROP(a_last_clears, clk_i, rst_ni, (beat_i && last_i) |=> (phase_q == PH_NUM0_WS && off_q == '0 && !ovf_q), "packet state not cleared")

endmodule

@@ rtl/browse_packet_field_tokenizer.sv @@
// -----------------------------------------------------------------------------
// Browse packet field tokenizer
// Parses two decimal numbers and four strings from a byte stream per packet.
// -----------------------------------------------------------------------------
// The block takes one packet byte per cycle on its input stream unless stalled.
// The parse state advances in a single registered step per beat, so ordinary
// bytes flow at one per cycle with no gaps. A beat marked last loads a
// six-entry result bank, which then sends one result per cycle on the output
// stream while m_axis_tready is high; a further last beat is held off while
// that bank still drains, while ordinary bytes of the next packet keep flowing.
`include "assert_macros.svh"

module browse_packet_field_tokenizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] byte_value
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // [2:0] field_id, [34:3] number_value,
                                     // [45:35] field_start, [56:46] field_length
  output logic        m_axis_tuser,  // [0] truncated
  output logic        m_axis_tlast
);
  import bpft_pkg::*;

  packet_t    snap;
  packet_t    bank_q;
  field_id_e  idx_q, idx_d;
  logic       busy_q, busy_d;
  logic       s_beat, m_beat;
  logic [1:0] sidx;
  logic [NUM_W-1:0]   out_num;
  logic [FIELD_W-1:0] out_start, out_len;

  function automatic logic [FIELD_W-1:0] sat_field(input logic [CNT_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'(FIELD_MAX)) ? FIELD_MAX : w[FIELD_W-1:0];
  endfunction

  assign s_axis_tready = !busy_q || !s_axis_tlast;
  assign s_beat        = s_axis_tvalid && s_axis_tready;
  assign m_beat        = m_axis_tvalid && m_axis_tready;

  bpft_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .beat_i (s_beat),
    .byte_i (s_axis_tdata),
    .last_i (s_axis_tlast),
    .snap_o (snap)
  );

  always_comb begin
    idx_d  = idx_q;
    busy_d = busy_q;
    if (s_beat && s_axis_tlast) begin
      idx_d  = FID_TYPE;
      busy_d = 1'b1;
    end else if (m_beat) begin
      if (idx_q == FID_MODEL) begin
        busy_d = 1'b0;
      end else begin
        idx_d = field_id_e'(3'(idx_q) + 3'd1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= FID_TYPE;
      busy_q <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_beat && s_axis_tlast) begin
      bank_q <= snap;
    end
  end

  assign sidx = 2'(3'(idx_q) - 3'(FID_URI));

  always_comb begin
    out_num   = '0;
    out_start = '0;
    out_len   = '0;
    case (idx_q)
      FID_TYPE:  out_num = bank_q.numbers[0];
      FID_STATE: out_num = bank_q.numbers[1];
      FID_URI, FID_LOCATION, FID_INFO, FID_MODEL: begin
        out_start = sat_field(bank_q.starts[sidx]);
        out_len   = sat_field(bank_q.lengths[sidx]);
      end
      default: begin
        out_num = '0;
      end
    endcase
  end

  assign m_axis_tvalid = busy_q;
  assign m_axis_tdata  = {7'b0, out_len, out_start, out_num, 3'(idx_q)};
  assign m_axis_tuser  = bank_q.truncated;
  assign m_axis_tlast  = (idx_q == FID_MODEL);

  `ASSERT_PROP(a_bank_loads, clk_i, rst_ni,
               (s_beat && s_axis_tlast) |=> (m_axis_tvalid && idx_q == FID_TYPE),
               "result bank not started")
  `ASSERT_PROP(a_bank_drains, clk_i, rst_ni,
               (m_beat && idx_q == FID_MODEL) |=> !m_axis_tvalid,
               "result bank not released")
  `ASSERT_NEVER(a_no_overrun, clk_i, rst_ni,
                s_beat && s_axis_tlast && busy_q,
                "packet end while bank busy")

endmodule
